// ----- rtl/spq_pkg.sv -----
// Shared types, widths and codes of the severity priority queue.
package spq_pkg;

  // Store size and derived count width
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int OP_W     = 1;
  localparam int ID_W     = 16;
  localparam int INJ_W    = 3;
  localparam int PEOPLE_W = 16;
  localparam int PRIO_W   = 7;
  localparam int OCC_W    = 5;
  localparam int STATUS_W = 3;
  localparam int SUM_W    = PEOPLE_W + 1;

  // Priority arithmetic constants
  localparam logic [PRIO_W-1:0] PRIO_CAP      = 7'd100;
  localparam logic [3:0]        INJURY_WEIGHT = 4'd10;
  localparam logic [INJ_W-1:0]  INJURY_MIN    = 3'd1;
  localparam logic [INJ_W-1:0]  INJURY_MAX    = 3'd5;
  localparam logic [ID_W-1:0]   FIRST_NUMBER  = 16'd1;

  // Request kinds
  typedef enum logic [OP_W-1:0] {
    OP_REPORT = 1'b0,
    OP_SERVE  = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED   = 3'd0,
    ST_SERVED     = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FULL       = 3'd3,
    ST_BAD_INJURY = 3'd4
  } status_t;

  // One stored entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   victim;
    logic [ID_W-1:0]   number;
  } entry_t;

  // Command from the control stage to the sorted store
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t entry;
  } store_cmd_t;

endpackage

// ----- rtl/spq_prio.sv -----
// Priority computation and injury level check for an incoming report.
module spq_prio (
  input  logic [spq_pkg::INJ_W-1:0]    injury_level,
  input  logic [spq_pkg::PEOPLE_W-1:0] people_affected,
  output logic [spq_pkg::PRIO_W-1:0]   prio,
  output logic                         bad_injury
);
  import spq_pkg::*;

  logic [SUM_W-1:0] weighted;
  logic [SUM_W-1:0] sum;

  // injury * 10 + people, capped at 100
  assign weighted = SUM_W'(injury_level) * SUM_W'(INJURY_WEIGHT);
  assign sum      = weighted + SUM_W'(people_affected);
  assign prio     = (sum > SUM_W'(PRIO_CAP)) ? PRIO_CAP : sum[PRIO_W-1:0];

  // only levels 1 to 5 are valid
  assign bad_injury = (injury_level < INJURY_MIN) || (injury_level > INJURY_MAX);

endmodule

// ----- rtl/spq_store.sv -----
// Sorted register array: parallel-compare insert and pop from the head.
module spq_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spq_pkg::store_cmd_t       cmd,
  output spq_pkg::entry_t           head,
  output logic [spq_pkg::CNT_W-1:0] count,
  output logic [spq_pkg::CNT_W-1:0] count_nxt
);
  import spq_pkg::*;

  entry_t                 slot_r   [QUEUE_DEPTH];
  entry_t                 slot_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ge;
  logic [CNT_W-1:0]       count_r;

  // slots holding an entry of equal or higher priority (a prefix)
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < count_r) && (slot_r[i].prio >= cmd.entry.prio);
    end
  end

  // next contents: keep, take new word, shift down on insert, shift up on pop
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
    logic prev_ge;
    entry_t prev_e;
    entry_t next_e;

    if (g == 0) begin : g_first
      assign prev_ge = 1'b1;
      assign prev_e  = cmd.entry;
    end else begin : g_rest
      assign prev_ge = ge[g-1];
      assign prev_e  = slot_r[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = slot_r[g];
    end else begin : g_inner
      assign next_e = slot_r[g+1];
    end

    always_comb begin
      slot_nxt[g] = slot_r[g];
      if (cmd.ins && !ge[g]) begin
        slot_nxt[g] = prev_ge ? cmd.entry : prev_e;
      end else if (cmd.pop) begin
        slot_nxt[g] = next_e;
      end
    end
  end

  // occupancy after this command
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // payload slots need no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = slot_r[0];
  assign count = count_r;

endmodule

// ----- rtl/severity_priority_queue.sv -----
// Top level of the severity priority queue: input stage, control, result register.
//
//   channel | handshake            | word
//   --------+----------------------+----------------------------------------------
//   input   | start, busy          | in_op, in_victim_id, in_injury_level,
//           |                      | in_people_affected
//   result  | out_valid (strobe)   | out_status, out_request_id, out_served_victim,
//           |                      | out_priority_res, out_occupancy
//
// One request is taken every cycle; busy is always low. Each word passes through the input
// register (priority already computed) and then through the sorted store update and the result
// register before its result appears.
// Reset (rst_n low, synchronous) empties the store and sets the next number to 1.
// The receiver cannot stall; out_valid is a one-cycle strobe.
module severity_priority_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [spq_pkg::OP_W-1:0]       in_op,
  input  logic [spq_pkg::ID_W-1:0]       in_victim_id,
  input  logic [spq_pkg::INJ_W-1:0]      in_injury_level,
  input  logic [spq_pkg::PEOPLE_W-1:0]   in_people_affected,
  output logic                           out_valid,
  output logic [spq_pkg::STATUS_W-1:0]   out_status,
  output logic [spq_pkg::ID_W-1:0]       out_request_id,
  output logic [spq_pkg::ID_W-1:0]       out_served_victim,
  output logic [spq_pkg::PRIO_W-1:0]     out_priority_res,
  output logic [spq_pkg::OCC_W-1:0]      out_occupancy
);
  import spq_pkg::*;

  logic               accept;
  logic [PRIO_W-1:0]  prio_in;
  logic               bad_in;

  // input register
  logic               in_valid_r;
  op_t                op_r;
  logic [ID_W-1:0]    victim_r;
  logic [PRIO_W-1:0]  prio_r;
  logic               bad_r;

  // control
  store_cmd_t         cmd;
  entry_t             head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_nxt;
  logic [ID_W-1:0]    next_number_r;
  logic [ID_W-1:0]    next_number_nxt;
  status_t            status_nxt;
  logic [ID_W-1:0]    rid_nxt;
  logic [ID_W-1:0]    sv_nxt;
  logic [PRIO_W-1:0]  pr_nxt;

  // result register
  logic               res_valid_r;
  status_t            status_r;
  logic [ID_W-1:0]    rid_r;
  logic [ID_W-1:0]    sv_r;
  logic [PRIO_W-1:0]  pr_r;
  logic [OCC_W-1:0]   occ_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  spq_prio u_prio (
    .injury_level    (in_injury_level),
    .people_affected (in_people_affected),
    .prio            (prio_in),
    .bad_injury      (bad_in)
  );

  // capture the request word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_op);
      victim_r <= in_victim_id;
      prio_r   <= prio_in;
      bad_r    <= bad_in;
    end
  end

  // decide the outcome and drive the store
  always_comb begin
    cmd             = '0;
    cmd.entry.prio  = prio_r;
    cmd.entry.victim = victim_r;
    cmd.entry.number = next_number_r;
    next_number_nxt = next_number_r;
    status_nxt      = ST_EMPTY;
    rid_nxt         = '0;
    sv_nxt          = '0;
    pr_nxt          = '0;
    if (in_valid_r) begin
      if (op_r == OP_REPORT) begin
        if (bad_r) begin
          status_nxt = ST_BAD_INJURY;
        end else if (count == CNT_W'(QUEUE_DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins         = 1'b1;
          status_nxt      = ST_ACCEPTED;
          rid_nxt         = next_number_r;
          pr_nxt          = prio_r;
          next_number_nxt = next_number_r + ID_W'(1);
        end
      end else begin
        if (count == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd.pop    = 1'b1;
          status_nxt = ST_SERVED;
          rid_nxt    = head.number;
          sv_nxt     = head.victim;
          pr_nxt     = head.prio;
        end
      end
    end
  end

  spq_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .head      (head),
    .count     (count),
    .count_nxt (count_nxt)
  );

  // request numbering and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_number_r <= FIRST_NUMBER;
      res_valid_r   <= 1'b0;
    end else begin
      next_number_r <= next_number_nxt;
      res_valid_r   <= in_valid_r;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      status_r <= status_nxt;
      rid_r    <= rid_nxt;
      sv_r     <= sv_nxt;
      pr_r     <= pr_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_valid         = res_valid_r;
  assign out_status        = status_r;
  assign out_request_id    = rid_r;
  assign out_served_victim = sv_r;
  assign out_priority_res  = pr_r;
  assign out_occupancy     = occ_r;

`ifndef NO_ASSERTIONS
  // store never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("store count above depth");

  // after a pop the store holds one fewer entry and is below its depth
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (count == $past(count) - CNT_W'(1)) && (count != CNT_W'(QUEUE_DEPTH)))
    else $error("pop did not reduce count");

  // every accepted request yields a result strobe, via the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result strobe missing");

  // a full rejection only occurs with the store at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && status_nxt == ST_FULL) |-> (count == CNT_W'(QUEUE_DEPTH)) && !cmd.ins)
    else $error("full status with room left");
`endif

endmodule
